// ----- sv/tnc_pkg.sv -----
// ============================================================================
// tnc_pkg
// Shared types, constants and helpers for the tag nesting checker.
// ============================================================================
`default_nettype none

package tnc_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NAME_BYTES_DEF  = 7;

    localparam int CHAR_W  = 8;
    localparam int DEPTH_W = 5;

    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [2:0] {
        EV_OPEN      = 3'd0,
        EV_CLOSE     = 3'd1,
        EV_MISMATCH  = 3'd2,
        EV_EMPTY     = 3'd3,
        EV_FULL      = 3'd4,
        EV_TOO_LONG  = 3'd5
    } ev_code_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_NAME = 3'b010,
        PH_TAIL = 3'b100
    } phase_t;

    // Token parser report for the current byte
    typedef struct packed {
        logic tag_done;
        logic closing;
        logic too_long;
    } tok_evt_t;

    // Stack command for the current byte
    typedef struct packed {
        logic push;
        logic pop;
    } stk_op_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

`default_nettype wire

// ----- sv/tnc_token.sv -----
// ============================================================================
// tnc_token
// Token parser: tracks the token phase and builds the tag name byte by byte.
// ============================================================================
`default_nettype none

module tnc_token
    import tnc_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [CHAR_W-1:0]        char_cur,
    output tok_evt_t                      evt,
    output logic     [8*NAME_BYTES-1:0]   name
);

    localparam int NW = 8 * NAME_BYTES;
    localparam int LW = $clog2(NAME_BYTES + 1);

    phase_t          phase_reg, phase_next;
    logic [NW-1:0]   name_reg, name_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            closing_reg, closing_next;

    always_comb
    begin
        phase_next   = phase_reg;
        name_next    = name_reg;
        len_next     = len_reg;
        closing_next = closing_reg;
        evt          = '0;
        evt.closing  = closing_reg;
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!is_space(char_cur))
                    begin
                        name_next    = '0;
                        len_next     = '0;
                        closing_next = (char_cur == CHAR_SLASH);
                        phase_next   = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (is_space(char_cur))
                    begin
                        name_next    = '0;
                        len_next     = '0;
                        closing_next = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                    else if (char_cur == CHAR_GT)
                    begin
                        evt.tag_done = 1'b1;
                        name_next    = '0;
                        len_next     = '0;
                        closing_next = 1'b0;
                        phase_next   = PH_TAIL;
                    end
                    else if (char_cur == CHAR_SLASH)
                    begin
                        closing_next = 1'b1;
                    end
                    else if (char_cur != CHAR_NUL)
                    begin
                        if (len_reg >= LW'(NAME_BYTES))
                        begin
                            evt.too_long = 1'b1;
                        end
                        else
                        begin
                            // place the byte at the next free slot
                            for (int i = 0; i < NAME_BYTES; i++)
                            begin
                                if (len_reg == LW'(i))
                                begin
                                    name_next[8*i +: 8] = char_cur;
                                end
                            end
                            len_next = len_reg + LW'(1);
                        end
                    end
                end
                PH_TAIL:
                begin
                    if (is_space(char_cur))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign name = name_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            name_reg    <= '0;
            len_reg     <= '0;
            closing_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            name_reg    <= name_next;
            len_reg     <= len_next;
            closing_reg <= closing_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tnc_stack.sv -----
// ============================================================================
// tnc_stack
// Name stack: memory plus a registered top entry and a prefetched second one.
// ============================================================================
`default_nettype none

module tnc_stack
    import tnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire stk_op_t                              op,
    input  wire logic [8*NAME_BYTES-1:0]              push_name,
    output logic      [$clog2(STACK_DEPTH+1)-1:0]     count,
    output logic      [8*NAME_BYTES-1:0]              top_name
);

    localparam int NW = 8 * NAME_BYTES;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [NW-1:0] mem [STACK_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [NW-1:0] top_reg, top_next;
    logic [NW-1:0] below_reg;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (op.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = push_name;
        end
        else if (op.pop)
        begin
            count_next = count_reg - CW'(1);
            top_next   = below_reg;
        end
    end

    // entry just below the next top; unused while fewer than two are held
    assign rd_addr = count_next[AW-1:0] - AW'(2);

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[count_reg[AW-1:0]] <= push_name;
        end
        below_reg <= mem[rd_addr];
        top_reg   <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count    = count_reg;
    assign top_name = top_reg;

endmodule

`default_nettype wire

// ----- sv/tag_nesting_checker.sv -----
// ============================================================================
// tag_nesting_checker
// Checks that markup tags in a byte stream are properly nested.
// ============================================================================
// The block takes one byte of markup text per request and sustains one byte
// per clock cycle while the result channel is not stalled. A byte is held in
// the input register and passes through one decode stage into the result
// register when that register can take a result. The rate is set by that
// single decode stage: the token parser and one stack operation (push, pop
// or compare against the top name) finish in the same cycle, because the top
// name sits in a register and the entry beneath it is prefetched from the
// stack memory every cycle. Whitespace separates tokens, the first byte of a
// token is skipped, a slash marks a closing tag, and '>' ends the name. Bytes
// that end a tag or overflow a name give one result; all other bytes give
// none. After an error, or once a close empties the stack (well_nested set),
// the block halts: it keeps taking bytes and drops them until reset. The
// stack memory needs no clearing pass after reset.
// ============================================================================
`default_nettype none

module tag_nesting_checker
    import tnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // byte request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CHAR_W-1:0]  char_in,
    // result request channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              event_code,
    output logic [DEPTH_W-1:0]      nest_depth,
    output logic                    halted_now,
    output logic                    well_nested
);

    localparam int NW = 8 * NAME_BYTES;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    ev_code_t           code_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               halt_reg;
    logic               good_reg;

    logic stopped_reg, stopped_next;

    logic     accept;
    logic     advance;
    logic     step;
    tok_evt_t tok_evt;
    logic [NW-1:0] tok_name;
    stk_op_t  stk_op;
    logic [CW-1:0] count;
    logic [NW-1:0] top_name;

    // decode results
    logic          emit;
    ev_code_t      code_cur;
    logic [CW-1:0] depth_cur;
    logic          halt_cur;
    logic          good_cur;

    // Advance the held byte whenever the result register can take a result.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    // Drop bytes once halted.
    assign step     = advance && !stopped_reg;

    tnc_token #(
        .NAME_BYTES (NAME_BYTES)
    ) u_token (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .char_cur (char_reg),
        .evt      (tok_evt),
        .name     (tok_name)
    );

    tnc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (stk_op),
        .push_name (tok_name),
        .count     (count),
        .top_name  (top_name)
    );

    // Decide the event for the current byte.
    always_comb
    begin
        emit      = 1'b0;
        code_cur  = EV_OPEN;
        depth_cur = count;
        halt_cur  = 1'b0;
        good_cur  = 1'b0;
        stk_op    = '0;
        if (step)
        begin
            if (tok_evt.too_long)
            begin
                emit     = 1'b1;
                code_cur = EV_TOO_LONG;
                halt_cur = 1'b1;
            end
            else if (tok_evt.tag_done && tok_evt.closing)
            begin
                emit = 1'b1;
                if (count == '0)
                begin
                    code_cur = EV_EMPTY;
                    halt_cur = 1'b1;
                end
                else if (top_name != tok_name)
                begin
                    code_cur = EV_MISMATCH;
                    halt_cur = 1'b1;
                end
                else
                begin
                    // matching close: pop, and halt as balanced on empty
                    stk_op.pop = 1'b1;
                    code_cur   = EV_CLOSE;
                    depth_cur  = count - CW'(1);
                    halt_cur   = (count == CW'(1));
                    good_cur   = (count == CW'(1));
                end
            end
            else if (tok_evt.tag_done)
            begin
                emit = 1'b1;
                if (count >= CW'(STACK_DEPTH))
                begin
                    code_cur = EV_FULL;
                    halt_cur = 1'b1;
                end
                else
                begin
                    stk_op.push = 1'b1;
                    code_cur    = EV_OPEN;
                    depth_cur   = count + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign stopped_next = stopped_reg || (emit && halt_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            stopped_reg   <= stopped_next;
        end
    end

    // Payload registers: hold unless loaded.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
        end
        if (emit)
        begin
            code_reg  <= code_cur;
            depth_reg <= depth_cur[DEPTH_W-1:0];
            halt_reg  <= halt_cur;
            good_reg  <= good_cur;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_code  = code_reg;
    assign nest_depth  = depth_reg;
    assign halted_now  = halt_reg;
    assign well_nested = good_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A halting result is always backed by the stopped flag.
    a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && halt_reg) |-> stopped_reg)
    else $error("halting result shown while block not stopped");

    // Balanced report only from a matching close that emptied the stack.
    a_good_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && good_reg) |->
            (code_reg == EV_CLOSE && depth_reg == '0 && halt_reg))
    else $error("well_nested reported on a non-emptying close");

    // Stack count stays within its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

    // No stack operation once halted.
    a_no_op_halted: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> $stable(count))
    else $error("stack changed after halt");

endmodule

`default_nettype wire
